// ===== sv/flow_consensus_average_node_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Consensus node assertion macros
// Shared property forms for the checks at the end of the consensus node.
// ----------------------------------------------------------------------------
`ifndef FLOW_CONSENSUS_AVERAGE_NODE_UNIT_MACROS_SVH
`define FLOW_CONSENSUS_AVERAGE_NODE_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define FCAN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FCAN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/fcan_pkg.sv =====
// ----------------------------------------------------------------------------
// Consensus node package
// Item types, sequencer states, codes and saturation helper.
// ----------------------------------------------------------------------------
package fcan_pkg;

  localparam int VAL_W   = 32;
  localparam int GAIN_W  = 16;
  localparam int LABEL_W = 8;
  localparam int MASK_W  = 6;
  localparam int CH_W    = 3;
  localparam int ACC_W   = 36;
  localparam int PROD_W  = ACC_W + GAIN_W + 1;
  localparam int FLR_W   = PROD_W - GAIN_W;
  localparam int SAT_W   = 40;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_MSG  = 2'd1;
  localparam logic [1:0] CMD_SET  = 2'd2;

  localparam logic [1:0] REG_GAMMA = 2'd0;
  localparam logic [1:0] REG_PHI   = 2'd1;
  localparam logic [1:0] REG_LABEL = 2'd2;
  localparam logic [1:0] REG_MASK  = 2'd3;

  localparam logic [CH_W-1:0] BCAST_CH = 3'd6;

  typedef struct packed {
    logic [1:0]              command;
    logic [LABEL_W-1:0]      msg_label;
    logic                    msg_is_reply;
    logic signed [VAL_W-1:0] msg_value;
    logic [CH_W-1:0]         rx_channel;
    logic signed [VAL_W-1:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]         tx_channel;
    logic                    tx_is_reply;
    logic [LABEL_W-1:0]      tx_label;
    logic signed [VAL_W-1:0] tx_value;
    logic signed [VAL_W-1:0] estimate;
    logic                    last;
  } out_item_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SUM   = 7'b0000010,
    S_EMUL  = 7'b0000100,
    S_EUPD  = 7'b0001000,
    S_BCAST = 7'b0010000,
    S_FMUL  = 7'b0100000,
    S_FUPD  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic any_present;
    logic cur_present;
    logic more_above;
    logic out_free;
  } seq_status_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v[SAT_W-1:VAL_W-1] == {(SAT_W-VAL_W+1){v[SAT_W-1]}}) begin
      r = v[VAL_W-1:0];
    end else if (v[SAT_W-1]) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== sv/fcan_mul.sv =====
// ----------------------------------------------------------------------------
// Consensus node gain multiplier
// Shared registered gain times operand product, floored by dropping the gain's fraction bits.
// ----------------------------------------------------------------------------
module fcan_mul
  import fcan_pkg::*;
(
  input  logic                    clk,
  input  logic                    load,
  input  logic [GAIN_W-1:0]       gain,
  input  logic signed [ACC_W-1:0] opnd,
  output logic signed [FLR_W-1:0] prod
);

  logic signed [PROD_W-1:0] full;

  assign full = $signed({1'b0, gain}) * opnd;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= full[PROD_W-1:GAIN_W];
    end
  end

endmodule

// ===== sv/fcan_seq.sv =====
// ----------------------------------------------------------------------------
// Consensus node sequencer
// Steps a tick through the flow sum, estimate update, broadcast and per-channel replies.
// ----------------------------------------------------------------------------
module fcan_seq
  import fcan_pkg::*;
#(
  parameter int CHANNELS = 6,
  parameter int CW = 3
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_start,
  input  seq_status_t status,
  output state_t      state,
  output logic [CW-1:0] cnt
);

  state_t        state_next;
  logic [CW-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      S_IDLE: begin
        if (tick_start) begin
          state_next = S_SUM;
          cnt_next   = '0;
        end
      end
      S_SUM: begin
        if (cnt == CW'(CHANNELS - 1)) begin
          state_next = S_EMUL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_EMUL: state_next = S_EUPD;
      S_EUPD: state_next = S_BCAST;
      S_BCAST: begin
        if (status.out_free) begin
          cnt_next   = '0;
          state_next = status.any_present ? S_FMUL : S_IDLE;
        end
      end
      S_FMUL: begin
        if (status.cur_present) begin
          state_next = S_FUPD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_FUPD: begin
        if (status.out_free) begin
          if (status.more_above) begin
            cnt_next   = cnt + 1'b1;
            state_next = S_FMUL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// ===== sv/flow_consensus_average_node_unit.sv =====
// A tick item runs the flow sum over every channel, the estimate product and update,
// then gives the broadcast item; after it a reply item follows for each present
// channel, with absent channels passed over on the way, and output stalls hold it.
// Message and set items are taken one per cycle while idle; a tick holds off the
// input until its last item is registered. Synchronous active-high reset restores
// the register defaults and clears the sequencer, values, flows, estimates and out_valid.
// ----------------------------------------------------------------------------
// Consensus node top level
// One node of a flow-based average consensus with a shared gain multiplier.
// ----------------------------------------------------------------------------
`include "flow_consensus_average_node_unit_macros.svh"

module flow_consensus_average_node_unit
  import fcan_pkg::*;
#(
  parameter int CHANNELS = 6
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [GAIN_W-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_item
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [GAIN_W-1:0]  gamma_gain;
  logic [GAIN_W-1:0]  phi_gain;
  logic [LABEL_W-1:0] node_label;
  logic [MASK_W-1:0]  neighbor_mask;

  logic signed [VAL_W-1:0] estimate_reg;
  logic signed [VAL_W-1:0] local_value;
  logic signed [VAL_W-1:0] link_flow [CHANNELS];
  logic signed [VAL_W-1:0] neighbor_estimate [CHANNELS];
  logic signed [ACC_W-1:0] acc;

  state_t        state;
  logic [CW-1:0] cnt;
  seq_status_t   status;

  logic [CHANNELS-1:0]     pres;
  logic                    more_above;
  logic                    in_fire;
  logic                    tick_start;
  logic [CW-1:0]           rx_idx;
  logic                    rx_ok;
  logic [CW-1:0]           rd_idx;
  logic signed [VAL_W-1:0] flow_rd;
  logic signed [VAL_W-1:0] nbr_rd;
  logic                    mul_load;
  logic [GAIN_W-1:0]       mul_gain;
  logic signed [ACC_W-1:0] mul_opnd;
  logic signed [FLR_W-1:0] prod;
  logic signed [VAL_W-1:0] delta;
  logic signed [VAL_W:0]   diff;
  logic                    out_free;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_pres
    if (g < MASK_W) begin : g_on
      assign pres[g] = neighbor_mask[g];
    end else begin : g_off
      assign pres[g] = 1'b0;
    end
  end

  always_comb begin
    more_above = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (pres[i] && (CW'(i) > cnt)) begin
        more_above = 1'b1;
      end
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign tick_start = in_fire && (in_item.command == CMD_TICK);
  assign out_free   = !out_valid || out_ready;
  assign rx_idx     = in_item.rx_channel[CW-1:0];
  assign rx_ok      = (32'(in_item.rx_channel) < CHANNELS) &&
                      (in_item.msg_label == node_label);
  assign rd_idx     = (state == S_IDLE) ? rx_idx : cnt;
  assign flow_rd    = link_flow[rd_idx];
  assign nbr_rd     = neighbor_estimate[cnt];
  assign diff       = (VAL_W+1)'(nbr_rd) - (VAL_W+1)'(estimate_reg);

  assign status.any_present = |pres;
  assign status.cur_present = pres[cnt];
  assign status.more_above  = more_above;
  assign status.out_free    = out_free;

  assign mul_load = (state == S_EMUL) || ((state == S_FMUL) && pres[cnt]);
  assign mul_gain = (state == S_EMUL) ? gamma_gain : phi_gain;
  assign mul_opnd = (state == S_EMUL) ? acc : ACC_W'(diff);
  assign delta    = sat32(SAT_W'(prod));

  fcan_seq #(
    .CHANNELS(CHANNELS),
    .CW(CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .tick_start(tick_start),
    .status    (status),
    .state     (state),
    .cnt       (cnt)
  );

  fcan_mul u_mul (
    .clk (clk),
    .load(mul_load),
    .gain(mul_gain),
    .opnd(mul_opnd),
    .prod(prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_gain    <= GAIN_W'(6554);
      phi_gain      <= GAIN_W'(3277);
      node_label    <= LABEL_W'(1);
      neighbor_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GAMMA: gamma_gain    <= cfg_data;
        REG_PHI:   phi_gain      <= cfg_data;
        REG_LABEL: node_label    <= cfg_data[LABEL_W-1:0];
        REG_MASK:  neighbor_mask <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tick_start) begin
      acc <= ACC_W'(local_value) - ACC_W'(estimate_reg);
    end else if ((state == S_SUM) && pres[cnt]) begin
      acc <= acc + ACC_W'(flow_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate_reg <= '0;
      local_value  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        link_flow[i]         <= '0;
        neighbor_estimate[i] <= '0;
      end
    end else begin
      if (in_fire && (in_item.command == CMD_MSG) && rx_ok) begin
        if (in_item.msg_is_reply) begin
          link_flow[rx_idx] <= sat32(SAT_W'(flow_rd) - SAT_W'(in_item.msg_value));
        end else begin
          neighbor_estimate[rx_idx] <= in_item.msg_value;
        end
      end
      if (in_fire && (in_item.command == CMD_SET)) begin
        local_value  <= in_item.new_value;
        estimate_reg <= sat32(SAT_W'(estimate_reg) + SAT_W'(in_item.new_value) -
                              SAT_W'(local_value));
      end
      if (state == S_EUPD) begin
        estimate_reg <= sat32(SAT_W'(estimate_reg) + SAT_W'(prod));
      end
      if ((state == S_FUPD) && out_free) begin
        link_flow[cnt] <= sat32(SAT_W'(flow_rd) + SAT_W'(delta));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (((state == S_BCAST) || (state == S_FUPD)) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_BCAST) && out_free) begin
      out_item.tx_channel  <= BCAST_CH;
      out_item.tx_is_reply <= 1'b0;
      out_item.tx_label    <= node_label;
      out_item.tx_value    <= estimate_reg;
      out_item.estimate    <= estimate_reg;
      out_item.last        <= ~(|pres);
    end else if ((state == S_FUPD) && out_free) begin
      out_item.tx_channel  <= CH_W'(cnt);
      out_item.tx_is_reply <= 1'b1;
      out_item.tx_label    <= node_label;
      out_item.tx_value    <= delta;
      out_item.estimate    <= estimate_reg;
      out_item.last        <= ~more_above;
    end
  end

  `FCAN_ASSERT_NEXT(a_tick_busy, tick_start, !in_ready, "tick item did not hold off input")
  `FCAN_ASSERT_NOW(a_reply_chan, out_valid && out_item.tx_is_reply, 32'(out_item.tx_channel) < CHANNELS, "reply item on a channel that does not exist")
  `FCAN_ASSERT_NOW(a_state_bcast, out_valid && !out_item.tx_is_reply, out_item.tx_channel == BCAST_CH, "state item not sent as broadcast")

endmodule
